// File: sv/assert_macros.svh
// Assertion helpers shared by the decoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is held.
`define AM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define AM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: sv/cuvd_pkg.sv
`default_nettype none

package cuvd_pkg;

    // Prefix byte thresholds
    localparam logic [7:0] PFX_TWO_BYTE  = 8'h80;
    localparam logic [7:0] PFX_FOUR_BYTE = 8'hC0;
    localparam logic [7:0] PFX_FIVE_BYTE = 8'hE0;

    // Value masks
    localparam logic [7:0]  MASK_7  = 8'h7F;
    localparam logic [31:0] MASK_14 = 32'h0000_3FFF;
    localparam logic [31:0] MASK_29 = 32'h1FFF_FFFF;

    // Total byte counts of a value, prefix included; zero means idle
    localparam logic [2:0] LEN_IDLE = 3'd0;
    localparam logic [2:0] LEN_TWO  = 3'd2;
    localparam logic [2:0] LEN_FOUR = 3'd4;
    localparam logic [2:0] LEN_FIVE = 3'd5;

    // Mask kinds
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_14   = 2'd1;
    localparam logic [1:0] KIND_29   = 2'd2;
    localparam logic [1:0] KIND_32   = 2'd3;

    // Result status codes
    localparam logic ST_OK        = 1'b0;
    localparam logic ST_UNDERFLOW = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] value;
        logic        status;
    } t_out_beat;

endpackage

`default_nettype wire

// File: sv/cuvd_core.sv
`default_nettype none

module cuvd_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_beat,
    input  wire cuvd_pkg::t_in_beat i_in,
    output logic                    o_res_valid,
    output cuvd_pkg::t_out_beat     o_res
);

`include "assert_macros.svh"

    logic [2:0]  r_exp, n_exp;
    logic [2:0]  r_seen, n_seen;
    logic [31:0] r_acc, n_acc;
    logic [1:0]  r_kind, n_kind;

    logic                res_v;
    cuvd_pkg::t_out_beat res;
    logic [2:0]          seen_inc;
    logic [31:0]         acc_sh;
    logic [31:0]         masked;

    assign seen_inc = r_seen + 3'd1;
    assign acc_sh   = {r_acc[23:0], i_in.data_byte};

    // Mask applied to the completed accumulator
    always_comb begin
        unique case (r_kind)
            cuvd_pkg::KIND_14: masked = acc_sh & cuvd_pkg::MASK_14;
            cuvd_pkg::KIND_29: masked = acc_sh & cuvd_pkg::MASK_29;
            default:           masked = acc_sh;
        endcase
    end

    // Next state and result for one byte
    always_comb begin
        n_exp  = r_exp;
        n_seen = r_seen;
        n_acc  = r_acc;
        n_kind = r_kind;
        res_v  = 1'b0;
        res    = '0;
        if (r_exp == cuvd_pkg::LEN_IDLE) begin
            if (i_in.data_byte < cuvd_pkg::PFX_TWO_BYTE) begin
                res_v        = 1'b1;
                res.value    = {24'd0, i_in.data_byte & cuvd_pkg::MASK_7};
                res.status   = cuvd_pkg::ST_OK;
            end else begin
                n_seen = 3'd1;
                if (i_in.data_byte < cuvd_pkg::PFX_FOUR_BYTE) begin
                    n_exp  = cuvd_pkg::LEN_TWO;
                    n_kind = cuvd_pkg::KIND_14;
                    n_acc  = {24'd0, i_in.data_byte};
                end else if (i_in.data_byte < cuvd_pkg::PFX_FIVE_BYTE) begin
                    n_exp  = cuvd_pkg::LEN_FOUR;
                    n_kind = cuvd_pkg::KIND_29;
                    n_acc  = {24'd0, i_in.data_byte};
                end else begin
                    n_exp  = cuvd_pkg::LEN_FIVE;
                    n_kind = cuvd_pkg::KIND_32;
                    n_acc  = '0;
                end
                if (i_in.last_byte) begin
                    res_v      = 1'b1;
                    res.status = cuvd_pkg::ST_UNDERFLOW;
                    n_exp      = cuvd_pkg::LEN_IDLE;
                    n_seen     = 3'd0;
                end
            end
        end else begin
            n_acc  = acc_sh;
            n_seen = seen_inc;
            if (seen_inc >= r_exp) begin
                res_v      = 1'b1;
                res.value  = masked;
                res.status = cuvd_pkg::ST_OK;
                n_exp      = cuvd_pkg::LEN_IDLE;
                n_seen     = 3'd0;
            end else if (i_in.last_byte) begin
                res_v      = 1'b1;
                res.status = cuvd_pkg::ST_UNDERFLOW;
                n_exp      = cuvd_pkg::LEN_IDLE;
                n_seen     = 3'd0;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp  <= cuvd_pkg::LEN_IDLE;
            r_seen <= 3'd0;
        end else if (i_beat) begin
            r_exp  <= n_exp;
            r_seen <= n_seen;
        end
    end

    // Accumulator and mask kind
    always_ff @(posedge i_clk) begin
        if (i_beat) begin
            r_acc  <= n_acc;
            r_kind <= n_kind;
        end
    end

    assign o_res_valid = i_beat & res_v;
    assign o_res       = res;

    // Terms for the checks below
    logic exp_legal;
    logic seen_ok;
    logic uflow_res;

    assign exp_legal = (r_exp == cuvd_pkg::LEN_IDLE) || (r_exp == cuvd_pkg::LEN_TWO) ||
                       (r_exp == cuvd_pkg::LEN_FOUR) || (r_exp == cuvd_pkg::LEN_FIVE);
    assign seen_ok   = (r_exp == cuvd_pkg::LEN_IDLE) || (r_seen != 3'd0 && r_seen < r_exp);
    assign uflow_res = o_res_valid && (o_res.status == cuvd_pkg::ST_UNDERFLOW);

    `AM_ASSERT(a_len_legal, i_clk, i_rst_n, exp_legal, "illegal value length")
    `AM_ASSERT(a_seen_range, i_clk, i_rst_n, seen_ok, "byte count out of range")
    `AM_ASSERT(a_uflow_zero, i_clk, i_rst_n, uflow_res |-> (o_res.value == '0), "underflow not zero")

endmodule

`default_nettype wire

// File: sv/cuvd_obuf.sv
`default_nettype none

module cuvd_obuf (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_load,
    input  wire cuvd_pkg::t_out_beat i_res,
    output logic                     o_ready,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output cuvd_pkg::t_out_beat      o_out_data
);

`include "assert_macros.svh"

    logic                r_valid, n_valid;
    cuvd_pkg::t_out_beat r_data;

    // Room for a new result when empty or draining this cycle
    assign o_ready = !r_valid || i_out_ready;

    always_comb begin
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_out_ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

    `AM_ASSERT(a_load_has_room, i_clk, i_rst_n, i_load |-> o_ready, "result loaded over a pending beat")
    `AM_ASSERT(a_load_shows, i_clk, i_rst_n, i_load |=> (o_out_valid && o_out_data == $past(i_res)), "loaded result not presented")

endmodule

`default_nettype wire

// File: sv/compact_uint_stream_decoder.sv
`default_nettype none

// Decodes prefix-length compact unsigned integers from a byte stream. Each
// input beat carries one byte and a last-byte flag; the first byte of a value
// selects one, two, four or five bytes. A result beat gives the 32-bit value
// with status 0, or value 0 with status 1 when the buffer ends mid-value.
// The decoder takes one byte per clock: the byte goes straight into the
// length counter and accumulator, and any result lands in a one-deep output
// register in the cycle after its last byte. Input ready drops only while
// that register holds a result the consumer has not taken.
module compact_uint_stream_decoder (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire cuvd_pkg::t_in_beat  i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output cuvd_pkg::t_out_beat      o_out_data
);

    logic                beat;
    logic                res_valid;
    cuvd_pkg::t_out_beat res;
    logic                obuf_ready;

    assign o_in_ready = obuf_ready;
    assign beat       = i_in_valid && obuf_ready;

    cuvd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_beat      (beat),
        .i_in        (i_in_data),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    cuvd_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (res_valid),
        .i_res       (res),
        .o_ready     (obuf_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
